// ----- rtl/npt_pkg.sv -----
//------------------------------------------------------------------------------
// npt_pkg
// Shared widths, types and the term lookup table of the normalized
// polynomial term core.
//------------------------------------------------------------------------------
`default_nettype none

package npt_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Divider widths: difference/span magnitudes and quotient with fraction
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int QUO_W   = DIFF_W + FRAC_BITS;
    // prep stage + one stage per quotient bit + finishing stage
    localparam int DIV_LAT = QUO_W + 2;

    // Product widths
    localparam int PROD_W  = 3 * COORD_WIDTH;
    localparam int VALUE_W = 64;
    localparam int SHIFT_W = PROD_W + 32;

    // Stream widths
    localparam int IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int CODE_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int TERM_COUNT = 18;

    localparam logic [VALUE_W-1:0] VALUE_ONE = 64'h0000_0001_0000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    typedef logic [CODE_W-1:0] code_t;

    // Factor source: one of the axes, or the constant one for padding
    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_ONE = 2'd3
    } axis_t;

    typedef struct packed {
        axis_t      a0;
        axis_t      a1;
        axis_t      a2;
        logic [1:0] deg;
    } term_sel_t;

    // Normalized coordinate as sign and magnitude
    typedef struct packed {
        logic [COORD_WIDTH-1:0] mag;
        logic                   neg;
        logic                   sat;
    } norm_t;

    // One stage of the restoring divider
    typedef struct packed {
        logic [DIFF_W-1:0]      rem;
        logic [DIFF_W-1:0]      ms;
        logic [QUO_W-1:0]       dvd;
        logic [QUO_W-1:0]       quo;
        logic                   neg;
        logic                   zero;
        logic                   raw_neg;
        logic [COORD_WIDTH-1:0] raw_mag;
    } div_stage_t;

    // Term code to factor axes and degree
    function automatic term_sel_t term_lookup(input code_t code);
        term_sel_t t;
        case (code)
            5'd0:    t = '{AXIS_X,   AXIS_ONE, AXIS_ONE, 2'd1};
            5'd1:    t = '{AXIS_X,   AXIS_X,   AXIS_ONE, 2'd2};
            5'd2:    t = '{AXIS_X,   AXIS_X,   AXIS_X,   2'd3};
            5'd3:    t = '{AXIS_Y,   AXIS_ONE, AXIS_ONE, 2'd1};
            5'd4:    t = '{AXIS_Y,   AXIS_Y,   AXIS_ONE, 2'd2};
            5'd5:    t = '{AXIS_Y,   AXIS_Y,   AXIS_Y,   2'd3};
            5'd6:    t = '{AXIS_Z,   AXIS_ONE, AXIS_ONE, 2'd1};
            5'd7:    t = '{AXIS_Z,   AXIS_Z,   AXIS_ONE, 2'd2};
            5'd8:    t = '{AXIS_Z,   AXIS_Z,   AXIS_Z,   2'd3};
            5'd9:    t = '{AXIS_X,   AXIS_Y,   AXIS_ONE, 2'd2};
            5'd10:   t = '{AXIS_X,   AXIS_Z,   AXIS_ONE, 2'd2};
            5'd11:   t = '{AXIS_Y,   AXIS_Z,   AXIS_ONE, 2'd2};
            5'd12:   t = '{AXIS_X,   AXIS_X,   AXIS_Y,   2'd3};
            5'd13:   t = '{AXIS_X,   AXIS_Y,   AXIS_Y,   2'd3};
            5'd14:   t = '{AXIS_X,   AXIS_X,   AXIS_Z,   2'd3};
            5'd15:   t = '{AXIS_X,   AXIS_Z,   AXIS_Z,   2'd3};
            5'd16:   t = '{AXIS_Y,   AXIS_Y,   AXIS_Z,   2'd3};
            5'd17:   t = '{AXIS_Y,   AXIS_Z,   AXIS_Z,   2'd3};
            default: t = '{AXIS_ONE, AXIS_ONE, AXIS_ONE, 2'd0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/npt_divider.sv -----
//------------------------------------------------------------------------------
// npt_divider
// Min-max normalization of one coordinate: (c - min) / (max - min) as a
// fixed-point quotient truncated toward zero, one quotient bit per stage.
//------------------------------------------------------------------------------
`default_nettype none

module npt_divider (
    input  wire logic                               aclk,
    input  wire logic                               ce,
    input  wire logic [npt_pkg::COORD_WIDTH-1:0]    coord,
    input  wire logic [npt_pkg::COORD_WIDTH-1:0]    lo,
    input  wire logic [npt_pkg::COORD_WIDTH-1:0]    hi,
    output npt_pkg::norm_t                          result
);

    localparam int CW = npt_pkg::COORD_WIDTH;
    localparam int DW = npt_pkg::DIFF_W;
    localparam int QW = npt_pkg::QUO_W;
    localparam int FB = npt_pkg::FRAC_BITS;

    npt_pkg::div_stage_t stage_reg [QW+1];
    npt_pkg::div_stage_t prep_next;
    npt_pkg::norm_t      result_reg;
    npt_pkg::norm_t      result_next;

    logic [DW-1:0] diff;
    logic [DW-1:0] span;
    logic [QW-1:0] lim;

    // Difference, span and their magnitudes
    always_comb begin
        diff = {coord[CW-1], coord} - {lo[CW-1], lo};
        span = {hi[CW-1], hi} - {lo[CW-1], lo};
        prep_next.rem     = '0;
        prep_next.ms      = span[DW-1] ? (DW)'(-span) : span;
        prep_next.dvd     = {(diff[DW-1] ? (DW)'(-diff) : diff), {FB{1'b0}}};
        prep_next.quo     = '0;
        prep_next.neg     = diff[DW-1] ^ span[DW-1];
        prep_next.zero    = (lo == hi);
        prep_next.raw_neg = coord[CW-1];
        prep_next.raw_mag = coord[CW-1] ? (CW)'(-coord) : coord;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            stage_reg[0] <= prep_next;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        npt_pkg::div_stage_t step_next;
        logic [DW:0]         shifted;
        logic [DW+1:0]       trial;

        always_comb begin
            step_next = stage_reg[k];
            shifted   = {stage_reg[k].rem, stage_reg[k].dvd[QW-1]};
            trial     = {1'b0, shifted} - {2'b00, stage_reg[k].ms};
            step_next.dvd = {stage_reg[k].dvd[QW-2:0], 1'b0};
            if (!trial[DW+1]) begin
                step_next.rem = trial[DW-1:0];
                step_next.quo = {stage_reg[k].quo[QW-2:0], 1'b1};
            end else begin
                step_next.rem = shifted[DW-1:0];
                step_next.quo = {stage_reg[k].quo[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                stage_reg[k+1] <= step_next;
            end
        end
    end

    // Clamp to the coordinate range; zero span passes the raw value
    always_comb begin
        lim = (QW)'({1'b1, {(CW-1){1'b0}}}) - (QW)'(!stage_reg[QW].neg);
        if (stage_reg[QW].zero) begin
            result_next.mag = stage_reg[QW].raw_mag;
            result_next.neg = stage_reg[QW].raw_neg;
            result_next.sat = 1'b0;
        end else if (stage_reg[QW].quo > lim) begin
            result_next.mag = lim[CW-1:0];
            result_next.neg = stage_reg[QW].neg;
            result_next.sat = 1'b1;
        end else begin
            result_next.mag = stage_reg[QW].quo[CW-1:0];
            result_next.neg = stage_reg[QW].neg;
            result_next.sat = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/normalized_polynomial_term_core.sv -----
//------------------------------------------------------------------------------
// normalized_polynomial_term_core
// Min-max normalized trend monomial of a point, up to degree three, Q32.32.
//------------------------------------------------------------------------------
// The core takes one word per clock and returns one word per input word, in
// order. The three normalizing dividers resolve one quotient bit per stage,
// followed by factor select, two multiply stages, a partial-product sum and
// the scale/saturate output register. Coordinates are Q16.16. The whole
// pipeline holds while a result waits on m_tready. Bounds must be written
// through the cfg port while idle; the core itself does not enforce this.
//------------------------------------------------------------------------------
`default_nettype none

module normalized_polynomial_term_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [npt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [npt_pkg::COORD_WIDTH-1:0]     cfg_data,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [npt_pkg::IN_DATA_W-1:0]       s_tdata,  // coord_x, coord_y, coord_z
    input  wire logic [npt_pkg::CODE_W-1:0]          s_tuser,  // term_code
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [npt_pkg::VALUE_W-1:0]              m_tdata,  // term_value
    output logic [1:0]                               m_tuser   // saturated, bad_code
);

    localparam int CW = npt_pkg::COORD_WIDTH;
    localparam int LAT = npt_pkg::DIV_LAT;
    localparam int VW = npt_pkg::VALUE_W;
    localparam int SW = npt_pkg::SHIFT_W;
    localparam int FB = npt_pkg::FRAC_BITS;

    logic ce;

    // Bounds
    logic [CW-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg, min_z_reg, max_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            min_z_reg <= '0;
            max_z_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                npt_pkg::CFG_MIN_X: min_x_reg <= cfg_data;
                npt_pkg::CFG_MAX_X: max_x_reg <= cfg_data;
                npt_pkg::CFG_MIN_Y: min_y_reg <= cfg_data;
                npt_pkg::CFG_MAX_Y: max_y_reg <= cfg_data;
                npt_pkg::CFG_MIN_Z: min_z_reg <= cfg_data;
                npt_pkg::CFG_MAX_Z: max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Global advance: move when the output slot is free or being taken
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Normalizing dividers
    npt_pkg::norm_t nx, ny, nz;

    npt_divider u_div_x (
        .aclk(aclk), .ce(ce), .coord(s_tdata[CW-1:0]),
        .lo(min_x_reg), .hi(max_x_reg), .result(nx)
    );
    npt_divider u_div_y (
        .aclk(aclk), .ce(ce), .coord(s_tdata[2*CW-1:CW]),
        .lo(min_y_reg), .hi(max_y_reg), .result(ny)
    );
    npt_divider u_div_z (
        .aclk(aclk), .ce(ce), .coord(s_tdata[3*CW-1:2*CW]),
        .lo(min_z_reg), .hi(max_z_reg), .result(nz)
    );

    // Valid and term code alongside the dividers
    logic                  vld_reg  [LAT];
    npt_pkg::code_t        code_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            code_reg[0] <= s_tuser;
            for (int i = 1; i < LAT; i++) begin
                code_reg[i] <= code_reg[i-1];
            end
        end
    end

    // Factor select
    function automatic npt_pkg::norm_t pick(input npt_pkg::norm_t ax, input npt_pkg::norm_t ay,
                                            input npt_pkg::norm_t az, input npt_pkg::axis_t a);
        npt_pkg::norm_t r;
        case (a)
            npt_pkg::AXIS_X: r = ax;
            npt_pkg::AXIS_Y: r = ay;
            npt_pkg::AXIS_Z: r = az;
            default:         r = '{mag: (CW)'(1), neg: 1'b0, sat: 1'b0};
        endcase
        return r;
    endfunction

    npt_pkg::term_sel_t tsel;
    npt_pkg::norm_t     f0, f1, f2;

    logic          sel_vld_reg;
    logic [CW-1:0] sel_f0_reg, sel_f1_reg, sel_f2_reg;
    logic          sel_neg_reg, sel_sat_reg, sel_bad_reg;
    logic [1:0]    sel_deg_reg;

    always_comb begin
        tsel = npt_pkg::term_lookup(code_reg[LAT-1]);
        f0   = pick(nx, ny, nz, tsel.a0);
        f1   = pick(nx, ny, nz, tsel.a1);
        f2   = pick(nx, ny, nz, tsel.a2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_vld_reg <= 1'b0;
        end else if (ce) begin
            sel_vld_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sel_f0_reg  <= f0.mag;
            sel_f1_reg  <= f1.mag;
            sel_f2_reg  <= f2.mag;
            sel_neg_reg <= f0.neg ^ f1.neg ^ f2.neg;
            sel_sat_reg <= f0.sat | f1.sat | f2.sat;
            sel_deg_reg <= tsel.deg;
            sel_bad_reg <= (code_reg[LAT-1] >= npt_pkg::CODE_W'(npt_pkg::TERM_COUNT));
        end
    end

    // First multiply
    logic            mul1_vld_reg;
    logic [2*CW-1:0] mul1_p_reg;
    logic [2*CW-1:0] mul1_p_next;
    logic [CW-1:0]   mul1_f2_reg;
    logic            mul1_neg_reg, mul1_sat_reg, mul1_bad_reg;
    logic [1:0]      mul1_deg_reg;

    assign mul1_p_next = sel_f0_reg * sel_f1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul1_vld_reg <= 1'b0;
        end else if (ce) begin
            mul1_vld_reg <= sel_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mul1_p_reg   <= mul1_p_next;
            mul1_f2_reg  <= sel_f2_reg;
            mul1_neg_reg <= sel_neg_reg;
            mul1_sat_reg <= sel_sat_reg;
            mul1_bad_reg <= sel_bad_reg;
            mul1_deg_reg <= sel_deg_reg;
        end
    end

    // Second multiply as two partial products
    logic            mul2_vld_reg;
    logic [2*CW-1:0] mul2_lo_reg, mul2_hi_reg;
    logic [2*CW-1:0] mul2_lo_next, mul2_hi_next;
    logic            mul2_neg_reg, mul2_sat_reg, mul2_bad_reg;
    logic [1:0]      mul2_deg_reg;

    assign mul2_lo_next = mul1_p_reg[CW-1:0] * mul1_f2_reg;
    assign mul2_hi_next = mul1_p_reg[2*CW-1:CW] * mul1_f2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul2_vld_reg <= 1'b0;
        end else if (ce) begin
            mul2_vld_reg <= mul1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mul2_lo_reg  <= mul2_lo_next;
            mul2_hi_reg  <= mul2_hi_next;
            mul2_neg_reg <= mul1_neg_reg;
            mul2_sat_reg <= mul1_sat_reg;
            mul2_bad_reg <= mul1_bad_reg;
            mul2_deg_reg <= mul1_deg_reg;
        end
    end

    // Partial-product sum
    logic                       sum_vld_reg;
    logic [npt_pkg::PROD_W-1:0] sum_p_reg;
    logic [npt_pkg::PROD_W-1:0] sum_p_next;
    logic                       sum_neg_reg, sum_sat_reg, sum_bad_reg;
    logic [1:0]                 sum_deg_reg;

    assign sum_p_next = {mul2_hi_reg, {CW{1'b0}}} + (npt_pkg::PROD_W)'(mul2_lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
        end else if (ce) begin
            sum_vld_reg <= mul2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_p_reg   <= sum_p_next;
            sum_neg_reg <= mul2_neg_reg;
            sum_sat_reg <= mul2_sat_reg;
            sum_bad_reg <= mul2_bad_reg;
            sum_deg_reg <= mul2_deg_reg;
        end
    end

    // Scale to Q32.32, saturate, apply sign
    logic [SW-1:0] wide;
    logic [SW-1:0] scaled;
    logic [VW-1:0] lim;
    logic [VW-1:0] mag;
    logic          over;
    logic [VW-1:0] value_next;
    logic [1:0]    user_next;

    always_comb begin
        wide = {sum_p_reg, 32'b0};
        case (sum_deg_reg)
            2'd1:    scaled = wide >> FB;
            2'd2:    scaled = wide >> (2 * FB);
            2'd3:    scaled = wide >> (3 * FB);
            default: scaled = wide;
        endcase
        lim  = npt_pkg::VALUE_MIN - (VW)'(!sum_neg_reg);
        over = (scaled[SW-1:VW] != '0) || (scaled[VW-1:0] > lim);
        mag  = over ? lim : scaled[VW-1:0];
        if (sum_bad_reg) begin
            value_next = npt_pkg::VALUE_ONE;
            user_next  = 2'b10;
        end else begin
            value_next = sum_neg_reg ? (VW)'(-mag) : mag;
            user_next  = {1'b0, over | sum_sat_reg};
        end
    end

    logic          m_tvalid_reg;
    logic [VW-1:0] m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= sum_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= value_next;
            m_tuser_reg <= user_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // An unknown code never reports saturation
    a_bad_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("bad code word flagged as saturated");

    // An unknown code returns exactly 1.0
    a_bad_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == npt_pkg::VALUE_ONE)
        else $error("bad code word value is not 1.0");

    // A saturated product sits at one of the range ends unless a factor clamped
    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        ce && sum_vld_reg && !sum_bad_reg && !sum_sat_reg && over |=>
        m_tdata == npt_pkg::VALUE_MAX || m_tdata == npt_pkg::VALUE_MIN)
        else $error("saturated product not clamped to range end");
`endif

endmodule

`default_nettype wire
